### hdl/msfm_pkg.sv
// Shared types, constants and reset values for the motor speed and fault monitor.
`default_nettype none

package msfm_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned TickW = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivCntW = $clog2(DataW);

  localparam logic [RegIdxW-1:0] REG_SPEED_SCALE = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LOW_VOLT_SET = 3'd1;
  localparam logic [RegIdxW-1:0] REG_LOW_VOLT_CLEAR = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TEMP_TRIP = 3'd3;
  localparam logic [RegIdxW-1:0] REG_TEMP_RELEASE = 3'd4;
  localparam logic [RegIdxW-1:0] REG_CURRENT_LIMIT = 3'd5;
  localparam logic [RegIdxW-1:0] REG_LOCK_SPEED_LIMIT = 3'd6;

  localparam logic [DataW-1:0] SPEED_SCALE_RST = 16'd61714;
  localparam logic [DataW-1:0] LOW_VOLT_SET_RST = 16'd27000;
  localparam logic [DataW-1:0] LOW_VOLT_CLEAR_RST = 16'd27500;
  localparam logic [DataW-1:0] TEMP_TRIP_RST = 16'd50000;
  localparam logic [DataW-1:0] TEMP_RELEASE_RST = 16'd48000;
  localparam logic [DataW-1:0] CURRENT_LIMIT_RST = 16'd20000;
  localparam logic [DataW-1:0] LOCK_SPEED_LIMIT_RST = 16'd60;

  localparam logic CMD_SPEED = 1'b0;
  localparam logic CMD_PROTECT = 1'b1;

  localparam logic [DataW-1:0] MIN_PERIOD = 16'd2;
  localparam logic [DataW-1:0] MIN_QUOTIENT = 16'd10;
  localparam logic [TickW-1:0] TICKS_MAX = 8'd255;
  localparam logic [TickW-1:0] TICKS_OC = 8'd10;
  localparam logic [TickW-1:0] TICKS_LOCK = 8'd100;
  localparam logic [TickW-1:0] TICKS_PINNED = 8'd200;

  typedef struct packed {
    logic             cmd;
    logic [DataW-1:0] step_period;
    logic [DataW-1:0] bus_voltage;
    logic [DataW-1:0] temperature;
    logic [DataW-1:0] phase_current;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] speed_rpm;
    logic             under_voltage;
    logic             over_temperature;
    logic             over_current;
    logic             rotor_locked;
  } out_t;

  typedef struct packed {
    logic [DataW-1:0] speed_scale;
    logic [DataW-1:0] low_volt_set;
    logic [DataW-1:0] low_volt_clear;
    logic [DataW-1:0] temp_trip;
    logic [DataW-1:0] temp_release;
    logic [DataW-1:0] current_limit;
    logic [DataW-1:0] lock_speed_limit;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic start_div;
    logic div_step;
    logic upd_speed;
    logic upd_prot;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_prot;
    logic period_long;
    logic div_last;
  } dp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hdl/msfm_regs.sv
// Configuration register file for the motor speed and fault monitor.
`default_nettype none

module msfm_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [msfm_pkg::RegIdxW-1:0]  cfg_index,
  input  wire logic [msfm_pkg::DataW-1:0]    cfg_data,
  output msfm_pkg::cfg_t                     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_scale <= msfm_pkg::SPEED_SCALE_RST;
      cfg.low_volt_set <= msfm_pkg::LOW_VOLT_SET_RST;
      cfg.low_volt_clear <= msfm_pkg::LOW_VOLT_CLEAR_RST;
      cfg.temp_trip <= msfm_pkg::TEMP_TRIP_RST;
      cfg.temp_release <= msfm_pkg::TEMP_RELEASE_RST;
      cfg.current_limit <= msfm_pkg::CURRENT_LIMIT_RST;
      cfg.lock_speed_limit <= msfm_pkg::LOCK_SPEED_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msfm_pkg::REG_SPEED_SCALE: cfg.speed_scale <= cfg_data;
        msfm_pkg::REG_LOW_VOLT_SET: cfg.low_volt_set <= cfg_data;
        msfm_pkg::REG_LOW_VOLT_CLEAR: cfg.low_volt_clear <= cfg_data;
        msfm_pkg::REG_TEMP_TRIP: cfg.temp_trip <= cfg_data;
        msfm_pkg::REG_TEMP_RELEASE: cfg.temp_release <= cfg_data;
        msfm_pkg::REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data;
        msfm_pkg::REG_LOCK_SPEED_LIMIT: cfg.lock_speed_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/msfm_dp.sv
// Datapath: input latch, shift-subtract divider, speed filter, fault flags, result register.
`default_nettype none

module msfm_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msfm_pkg::cfg_t       cfg,
  input  wire msfm_pkg::in_t        in_data,
  input  wire msfm_pkg::dp_cmd_t    cmd,
  output msfm_pkg::dp_status_t      status,
  output msfm_pkg::out_t            out_data
);

  localparam int unsigned W = msfm_pkg::DataW;

  msfm_pkg::in_t item;

  logic [W-1:0]                   speed;
  logic [W-1:0]                   speed_next;
  logic [msfm_pkg::TickW-1:0]     ticks;
  logic [msfm_pkg::TickW-1:0]     ticks_inc;
  logic                           uv_flag;
  logic                           ot_flag;
  logic                           oc_flag;
  logic                           lock_flag;

  logic [W:0]                     rem;
  logic [W-1:0]                   quo;
  logic [W:0]                     shifted;
  logic [W:0]                     trial;
  logic [msfm_pkg::DivCntW-1:0]   div_cnt;
  logic [W+3:0]                   filt_sum;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_data;
    end
  end

  assign status.is_prot = (item.cmd == msfm_pkg::CMD_PROTECT);
  assign status.period_long = (item.step_period > msfm_pkg::MIN_PERIOD);
  assign status.div_last = (div_cnt == msfm_pkg::DivCntW'(W - 1));

  assign shifted = {rem[W-1:0], quo[W-1]};
  assign trial = shifted - {1'b0, item.step_period};

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem <= '0;
      quo <= cfg.speed_scale;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign filt_sum = {4'b0000, quo} + {1'b0, speed, 3'b000} - {4'b0000, speed};

  always_comb begin
    if (quo < msfm_pkg::MIN_QUOTIENT) begin
      speed_next = '0;
    end else begin
      speed_next = filt_sum[W+2:3];
    end
  end

  assign ticks_inc = (ticks == msfm_pkg::TICKS_MAX) ? ticks : ticks + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      ticks <= '0;
      uv_flag <= 1'b0;
      ot_flag <= 1'b0;
      oc_flag <= 1'b0;
      lock_flag <= 1'b0;
    end else begin
      if (cmd.upd_speed) begin
        speed <= speed_next;
      end
      if (cmd.upd_prot) begin
        if (item.bus_voltage < cfg.low_volt_set) begin
          uv_flag <= 1'b1;
        end else if (item.bus_voltage > cfg.low_volt_clear) begin
          uv_flag <= 1'b0;
        end
        if (item.temperature > cfg.temp_trip) begin
          ot_flag <= 1'b1;
        end else if (item.temperature < cfg.temp_release) begin
          ot_flag <= 1'b0;
        end
        if (item.phase_current > cfg.current_limit) begin
          if (ticks_inc > msfm_pkg::TICKS_LOCK && speed < cfg.lock_speed_limit) begin
            ticks <= msfm_pkg::TICKS_PINNED;
            lock_flag <= 1'b1;
          end else begin
            ticks <= ticks_inc;
            if (ticks_inc > msfm_pkg::TICKS_OC) begin
              oc_flag <= 1'b1;
            end
          end
        end else begin
          ticks <= '0;
          oc_flag <= 1'b0;
          lock_flag <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.speed_rpm <= speed;
      out_data.under_voltage <= uv_flag;
      out_data.over_temperature <= ot_flag;
      out_data.over_current <= oc_flag;
      out_data.rotor_locked <= lock_flag;
    end
  end

endmodule

`default_nettype wire

### hdl/msfm_ctrl.sv
// Controller state machine sequencing transfers, division and state updates.
`default_nettype none

module msfm_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire msfm_pkg::dp_status_t    status,
  output msfm_pkg::dp_cmd_t            cmd
);

  msfm_pkg::state_t state;
  msfm_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msfm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msfm_pkg::S_IDLE: begin
        if (in_valid) state_next = msfm_pkg::S_EXEC;
      end
      msfm_pkg::S_EXEC: begin
        if (!status.is_prot && status.period_long) begin
          state_next = msfm_pkg::S_DIV;
        end else begin
          state_next = msfm_pkg::S_DONE;
        end
      end
      msfm_pkg::S_DIV: begin
        if (status.div_last) state_next = msfm_pkg::S_UPD;
      end
      msfm_pkg::S_UPD: state_next = msfm_pkg::S_DONE;
      msfm_pkg::S_DONE: begin
        if (out_free) state_next = msfm_pkg::S_IDLE;
      end
      default: state_next = msfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      msfm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load_in = in_valid;
      end
      msfm_pkg::S_EXEC: begin
        cmd.start_div = !status.is_prot && status.period_long;
        cmd.upd_prot = status.is_prot;
      end
      msfm_pkg::S_DIV: cmd.div_step = 1'b1;
      msfm_pkg::S_UPD: cmd.upd_speed = 1'b1;
      msfm_pkg::S_DONE: cmd.load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result overwritten while held");

  a_div_follows_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |=> (state == msfm_pkg::S_DIV))
    else $error("division not entered after start");

  a_upd_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == msfm_pkg::S_DIV && status.div_last) |=> cmd.upd_speed)
    else $error("speed update missing after last division step");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == msfm_pkg::S_DONE))
    else $error("result raised outside completion");
`endif

endmodule

`default_nettype wire

### hdl/motor_speed_and_fault_monitor_top.sv
// Top level of the motor speed and fault monitor.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one tick: cmd selects a
//   speed tick (step_period) or a protection tick (voltage, temperature,
//   current). Every tick transfer yields exactly one result on
//   out_valid/out_stall/out_data with the speed and the four fault flags.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high, indexes beyond six are dropped. Write only
//   while no tick is in flight.
//   Sequencing: a protection tick or a speed tick with period of two or less
//   goes from the transfer through EXEC to DONE; a speed tick with a longer
//   period also passes the 16 steps of the shift-subtract divider and the
//   speed update. One tick is in flight at a time; the next transfer is
//   taken in the cycle after the result is loaded.
//   A held result stalls only the final load; a new tick may be taken and
//   worked on while the previous result waits.
//   Reset (rst, synchronous) restores register defaults, clears speed,
//   counter and flags, and drops any pending result.
`default_nettype none

module motor_speed_and_fault_monitor_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire msfm_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output msfm_pkg::out_t                     out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [msfm_pkg::RegIdxW-1:0]  cfg_index,
  input  wire logic [msfm_pkg::DataW-1:0]    cfg_data
);

  msfm_pkg::cfg_t       cfg;
  msfm_pkg::dp_cmd_t    cmd;
  msfm_pkg::dp_status_t status;

  msfm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  msfm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### test/tb_motor_speed_and_fault_monitor_top.sv
// Self-checking testbench for the motor speed and fault monitor: shadow scoreboard, drivers, test sequence.
module tb_motor_speed_and_fault_monitor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msfm_pkg::*;

  localparam int HOLD_CYCLES = 70;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  typedef enum int {
    RUN_OVERCURRENT,
    RUN_SPEED,
    RUN_NOISE
  } run_t;

  class fault_shadow;
    cfg_t             regs;
    logic [DataW-1:0] speed;
    logic [TickW-1:0] oc_ticks;
    logic             uv;
    logic             ot;
    logic             oc;
    logic             lock;
    out_t             expected_q[$];
    int               errors;
    int               speed_ticks;
    int               prot_ticks;
    int               checked;
    int               lock_hits;
    int               sat_hits;

    function new();
      regs = '{SPEED_SCALE_RST, LOW_VOLT_SET_RST, LOW_VOLT_CLEAR_RST, TEMP_TRIP_RST,
               TEMP_RELEASE_RST, CURRENT_LIMIT_RST, LOCK_SPEED_LIMIT_RST};
      speed = '0;
      oc_ticks = '0;
      uv = 1'b0;
      ot = 1'b0;
      oc = 1'b0;
      lock = 1'b0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] val);
      case (idx)
        REG_SPEED_SCALE:      regs.speed_scale = val;
        REG_LOW_VOLT_SET:     regs.low_volt_set = val;
        REG_LOW_VOLT_CLEAR:   regs.low_volt_clear = val;
        REG_TEMP_TRIP:        regs.temp_trip = val;
        REG_TEMP_RELEASE:     regs.temp_release = val;
        REG_CURRENT_LIMIT:    regs.current_limit = val;
        REG_LOCK_SPEED_LIMIT: regs.lock_speed_limit = val;
        default: ;
      endcase
    endfunction

    function void note_tick(in_t t);
      logic [31:0] q;
      out_t        res;
      if (t.cmd == CMD_SPEED) begin
        speed_ticks++;
        if (t.step_period > MIN_PERIOD) begin
          q = {16'd0, regs.speed_scale} / {16'd0, t.step_period};
          if (q < 32'(MIN_QUOTIENT))
            speed = '0;
          else
            speed = 16'((q + 32'd7 * {16'd0, speed}) / 32'd8);
        end
      end else begin
        prot_ticks++;
        if (t.bus_voltage < regs.low_volt_set)
          uv = 1'b1;
        else if (t.bus_voltage > regs.low_volt_clear)
          uv = 1'b0;
        if (t.temperature > regs.temp_trip)
          ot = 1'b1;
        else if (t.temperature < regs.temp_release)
          ot = 1'b0;
        if (t.phase_current > regs.current_limit) begin
          if (oc_ticks < TICKS_MAX)
            oc_ticks = oc_ticks + 8'd1;
          else
            sat_hits++;
          if (oc_ticks > TICKS_LOCK && speed < regs.lock_speed_limit) begin
            oc_ticks = TICKS_PINNED;
            lock = 1'b1;
          end else if (oc_ticks > TICKS_OC) begin
            oc = 1'b1;
          end
        end else begin
          oc_ticks = '0;
          oc = 1'b0;
          lock = 1'b0;
        end
      end
      res.speed_rpm = speed;
      res.under_voltage = uv;
      res.over_temperature = ot;
      res.over_current = oc;
      res.rotor_locked = lock;
      expected_q.push_back(res);
    endfunction

    function void field_check(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result %h with nothing expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.rotor_locked === 1'b1)
        lock_hits++;
      field_check("speed_rpm", want.speed_rpm, got.speed_rpm);
      field_check("under_voltage", 16'(want.under_voltage), 16'(got.under_voltage));
      field_check("over_temperature", 16'(want.over_temperature), 16'(got.over_temperature));
      field_check("over_current", 16'(want.over_current), 16'(got.over_current));
      field_check("rotor_locked", 16'(want.rotor_locked), 16'(got.rotor_locked));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [RegIdxW-1:0]   cfg_index = '0;
  logic [DataW-1:0]     cfg_data = '0;

  fault_shadow shadow = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  run_t        run_kind = RUN_NOISE;
  int          run_left = 0;

  motor_speed_and_fault_monitor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_result(out_data);
  end

  function automatic in_t random_fields();
    in_t t;
    t.cmd = 1'($urandom);
    t.step_period = 16'($urandom);
    t.bus_voltage = 16'($urandom);
    t.temperature = 16'($urandom);
    t.phase_current = 16'($urandom);
    return t;
  endfunction

  function automatic in_t mk_speed(logic [DataW-1:0] period);
    in_t t;
    t = random_fields();
    t.cmd = CMD_SPEED;
    t.step_period = period;
    return t;
  endfunction

  function automatic in_t mk_protect(logic [DataW-1:0] volt, logic [DataW-1:0] temp,
                                     logic [DataW-1:0] cur);
    in_t t;
    t = random_fields();
    t.cmd = CMD_PROTECT;
    t.bus_voltage = volt;
    t.temperature = temp;
    t.phase_current = cur;
    return t;
  endfunction

  function automatic logic [DataW-1:0] near(logic [DataW-1:0] b);
    int x;
    x = int'(b) + int'($urandom_range(8)) - 4;
    if (x < 0)
      x = 0;
    if (x > 65535)
      x = 65535;
    return 16'(x);
  endfunction

  function automatic logic [DataW-1:0] pick_level(logic [DataW-1:0] a, logic [DataW-1:0] b);
    case ($urandom_range(3))
      0: return near(a);
      1: return near(b);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_period();
    case ($urandom_range(3))
      0: return 16'($urandom_range(2, 0));
      1: return 16'($urandom_range(400, 3));
      2: return 16'($urandom_range(8000, 401));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct = 56;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct = 56;
      end
      default: begin
        idle_pct = 32;
        stall_pct = 32;
      end
    endcase
  endtask

  task automatic send_tick(input in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    shadow.note_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    int               i;
    logic [DataW-1:0] d;
    for (i = 0; i < 8; i++) begin
      case (3'(i))
        REG_SPEED_SCALE:      d = c.speed_scale;
        REG_LOW_VOLT_SET:     d = c.low_volt_set;
        REG_LOW_VOLT_CLEAR:   d = c.low_volt_clear;
        REG_TEMP_TRIP:        d = c.temp_trip;
        REG_TEMP_RELEASE:     d = c.temp_release;
        REG_CURRENT_LIMIT:    d = c.current_limit;
        REG_LOCK_SPEED_LIMIT: d = c.lock_speed_limit;
        default:              d = 16'($urandom);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= d;
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
      shadow.write_reg(3'(i), d);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_tick(output in_t t);
    int unsigned lim;
    int          r;
    lim = shadow.regs.current_limit;
    if (run_left == 0) begin
      r = $urandom_range(99);
      if (r < 45) begin
        run_kind = RUN_OVERCURRENT;
        run_left = $urandom_range(130, 8);
      end else if (r < 75) begin
        run_kind = RUN_SPEED;
        run_left = $urandom_range(12, 3);
      end else begin
        run_kind = RUN_NOISE;
        run_left = $urandom_range(6, 1);
      end
    end
    run_left--;
    t = random_fields();
    case (run_kind)
      RUN_OVERCURRENT: begin
        if ($urandom_range(9) == 0) begin
          t.cmd = CMD_SPEED;
          t.step_period = pick_period();
        end else begin
          t.cmd = CMD_PROTECT;
          t.bus_voltage = pick_level(shadow.regs.low_volt_set, shadow.regs.low_volt_clear);
          t.temperature = pick_level(shadow.regs.temp_trip, shadow.regs.temp_release);
          if (lim < 65535 && $urandom_range(39) != 0)
            t.phase_current = 16'($urandom_range(65535, lim + 1));
        end
      end
      RUN_SPEED: begin
        t.cmd = CMD_SPEED;
        t.step_period = pick_period();
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input int n, input pace_t first, input bit saturate);
    in_t         t;
    int          i;
    int unsigned lim;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0)
        set_pace(pace_t'((int'(first) + i / 40) % 4));
      if (i == n / 3)
        hold_seq <= hold_seq + 1;
      if (saturate) begin
        lim = shadow.regs.current_limit;
        t = random_fields();
        if ($urandom_range(15) == 0) begin
          t.cmd = CMD_SPEED;
        end else begin
          t.cmd = CMD_PROTECT;
          t.phase_current = 16'($urandom_range(65535, lim + 1));
        end
      end else begin
        pick_tick(t);
      end
      send_tick(t);
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_pace(PACE_FULL);
    send_tick(mk_speed(16'd0));
    send_tick(mk_speed(16'd1));
    send_tick(mk_speed(16'd2));
    send_tick(mk_speed(16'd3));
    send_tick(mk_speed(16'd6171));
    send_tick(mk_speed(16'd6172));
    send_tick(mk_speed(16'hFFFF));
    send_tick(mk_protect(16'd0, 16'hFFFF, 16'hFFFF));
    send_tick(mk_protect(16'hFFFF, 16'd0, 16'd0));
    send_tick(mk_protect(LOW_VOLT_SET_RST, TEMP_TRIP_RST, CURRENT_LIMIT_RST));
    send_tick(mk_protect(LOW_VOLT_SET_RST - 16'd1, TEMP_TRIP_RST + 16'd1,
                         CURRENT_LIMIT_RST + 16'd1));
    send_tick(mk_protect(LOW_VOLT_CLEAR_RST, TEMP_RELEASE_RST, CURRENT_LIMIT_RST + 16'd1));
    send_tick(mk_protect(LOW_VOLT_CLEAR_RST + 16'd1, TEMP_RELEASE_RST - 16'd1,
                         CURRENT_LIMIT_RST + 16'd1));
    repeat (11)
      send_tick(mk_protect(16'($urandom), 16'($urandom), 16'hFFFF));
    drain();

    run_phase(60, PACE_FULL, 1'b0);
    drain();

    c = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
    write_config(c);
    run_phase(60, PACE_SENDER_IDLE, 1'b0);
    drain();

    c = '{16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
    write_config(c);
    run_phase(45, PACE_RECEIVER_STALL, 1'b0);
    drain();

    c.speed_scale = 16'($urandom_range(65535, 1));
    c.low_volt_set = 16'($urandom_range(40000, 20000));
    c.low_volt_clear = 16'($urandom_range(41000, 19000));
    c.temp_trip = 16'($urandom_range(60000, 40000));
    c.temp_release = 16'($urandom_range(61000, 39000));
    c.current_limit = 16'($urandom_range(60000, 0));
    c.lock_speed_limit = 16'($urandom_range(3000, 0));
    write_config(c);
    run_phase(60, PACE_BOTH, 1'b0);
    drain();

    c = '{SPEED_SCALE_RST, LOW_VOLT_SET_RST, LOW_VOLT_CLEAR_RST, TEMP_TRIP_RST,
          TEMP_RELEASE_RST, 16'($urandom_range(30000, 1000)), 16'd0};
    write_config(c);
    run_phase(310, PACE_FULL, 1'b1);
    drain();

    repeat (25) @(posedge clk);
    $display("covered %0d speed and %0d protection ticks over five register settings, %0d results",
             shadow.speed_ticks, shadow.prot_ticks, shadow.checked);
    $display("rotor lock held in %0d results, overcurrent counter saturated %0d times",
             shadow.lock_hits, shadow.sat_hits);
    if (shadow.errors == 0)
      $display("tb_motor_speed_and_fault_monitor_top: clean");
    else
      $display("tb_motor_speed_and_fault_monitor_top: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", shadow.expected_q.size());
    $display("tb_motor_speed_and_fault_monitor_top: errors");
    $finish;
  end

endmodule

### sim.f
hdl/msfm_pkg.sv
hdl/msfm_regs.sv
hdl/msfm_dp.sv
hdl/msfm_ctrl.sv
hdl/motor_speed_and_fault_monitor_top.sv
test/tb_motor_speed_and_fault_monitor_top.sv
